// ===== hw/rtl/mmft_pkg.sv =====
package mmft_pkg;

    localparam int MOTOR_COUNT_DEF     = 11;
    localparam int COUNTS_PER_TURN_DEF = 8192;
    localparam int MAX_MOTORS          = 12;
    localparam int MIDX_W              = 4;
    localparam int CFG_IDX_W           = 1;
    localparam int CFG_DATA_W          = 15;
    localparam int IN_DATA_W           = 152;
    localparam int OUT_DATA_W          = 216;

    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_TIMEOUT = 1'd1;

    localparam logic [14:0] CURRENT_LIMIT_RST   = 15'd16383;
    localparam logic [7:0]  SILENCE_TIMEOUT_RST = 8'd200;
    localparam logic [8:0]  SILENCE_RST         = 9'd200;

    localparam logic [10:0] ID_BASE      = 11'h201;
    localparam logic [10:0] IDENT_GROUP0 = 11'h200;
    localparam logic [10:0] IDENT_GROUP1 = 11'h1FF;
    localparam logic [10:0] IDENT_GROUP2 = 11'h2FF;

    typedef enum logic [2:0] {
        FUNC_FEEDBACK = 3'd0,
        FUNC_TICK     = 3'd1,
        FUNC_SET_CUR  = 3'd2,
        FUNC_SET_POS  = 3'd3,
        FUNC_SEND     = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_COMMAND = 2'd1,
        KIND_MASK    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_POS,
        ST_APPLY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [15:0] commanded_current;
        logic [10:0] connected_mask;
        logic [63:0] frame_bytes;
        logic [10:0] frame_ident;
        logic [31:0] frames_received;
        logic        is_connected;
        logic [7:0]  temperature_c;
        logic [15:0] measured_current;
        logic [15:0] speed_rpm;
        logic [31:0] position_counts;
        logic [3:0]  motor_index;
        logic [1:0]  result_kind;
    } result_t;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

endpackage

// ===== hw/rtl/mmft_alu.sv =====
module mmft_alu
    import mmft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  alu_req_t    req,
    output logic [32:0] sum
);

    logic [32:0] sum_reg;
    logic [32:0] sum_next;

    always_comb
    begin
        case (req.op)
            2'd0:    sum_next = {1'b0, req.a} + {1'b0, req.b};
            2'd1:    sum_next = {1'b0, req.a} - {1'b0, req.b};
            default: sum_next = {req.a[31], req.a} - {req.b[31], req.b};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (req.start)
            sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

// ===== hw/rtl/multi_motor_feedback_tracker.sv =====
// Feedback tracker for a group of motors on one bus.
// Slave stream s_axis carries one operation per item: feedback frame, tick,
// set current, set position or send group. Master stream m_axis returns at
// most one result per item: a motor status, a command frame or a connection
// mask. Unknown identifiers, out of range motors, group 3 and unused codes
// return nothing.
// Items are taken one at a time: s_axis_tready is high only while idle.
// Feedback, set current and send group pass through decode, apply and emit;
// set position adds ALU steps in the position state; a tick walks every motor
// through the shared counter logic, one motor per cycle. With the receiver
// ready the next item is taken in the cycle after the previous result is
// loaded; an item that returns nothing goes back to idle straight from decode.
// A result waits in the output register until m_axis_tready; meanwhile the
// next item is taken and worked on, then held in the emit state until the
// register frees up.
// Reset clears all motor state (silence counters to 200) and loads the
// register defaults. Registers are written through cfg_we/cfg_addr/cfg_data;
// the user must write them only while idle, which the block does not enforce.
module multi_motor_feedback_tracker
    import mmft_pkg::*;
#(
    parameter int MOTOR_COUNT     = MOTOR_COUNT_DEF,
    parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // func[2:0], can_id[13:3], payload[77:14], motor_select[81:78],
    // current_request[113:82], target_position[145:114], group_select[147:146]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // result_kind[1:0], motor_index[5:2], position_counts[37:6],
    // speed_rpm[53:38], measured_current[69:54], temperature_c[77:70],
    // is_connected[78], frames_received[110:79], frame_ident[121:111],
    // frame_bytes[185:122], connected_mask[196:186], commanded_current[212:197]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam logic [16:0] HALF = 17'(COUNTS_PER_TURN / 2);
    localparam logic [MIDX_W-1:0] LAST_M = MIDX_W'(MOTOR_COUNT - 1);

    logic [15:0] enc_reg  [MOTOR_COUNT];
    logic [31:0] turn_reg [MOTOR_COUNT];
    logic [15:0] off_reg  [MOTOR_COUNT];
    logic [15:0] spd_reg  [MOTOR_COUNT];
    logic [15:0] cur_reg  [MOTOR_COUNT];
    logic [7:0]  tmp_reg  [MOTOR_COUNT];
    logic [15:0] drv_reg  [MOTOR_COUNT];
    logic [8:0]  sil_reg  [MOTOR_COUNT];
    logic [31:0] frm_reg  [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] link_reg;

    logic [14:0] limit_reg;
    logic [7:0]  tmo_reg;

    state_t state_reg, state_next;
    logic [2:0]   func_reg;
    logic [10:0]  id_reg;
    logic [63:0]  pay_reg;
    logic [3:0]   sel_reg;
    logic [31:0]  req_reg;
    logic [31:0]  tgt_reg;
    logic [1:0]   grp_reg;
    logic [MIDX_W-1:0] m_reg;
    logic         valid_op;
    logic [MIDX_W-1:0] m_dec;
    logic [10:0]  id_off;
    logic [MIDX_W-1:0] walk_reg;
    logic         walk_last;
    logic [1:0]   pos_step_reg;
    result_t      res_reg;
    result_t      res_next;
    logic         out_valid_reg;
    logic         emit_load;

    alu_req_t     alu_req;
    logic [32:0]  alu_sum;
    logic [31:0]  pos_now;
    logic [MOTOR_COUNT-1:0] mask_next;
    result_t      stat;
    logic [15:0]  clamp_val;
    logic signed [31:0] req_s;
    logic signed [31:0] lim_s;
    logic [63:0]  grp_bytes;
    logic [15:0]  new_raw;
    logic signed [16:0] diff;

    mmft_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .sum   (alu_sum)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(res_reg);
    assign id_off        = id_reg - ID_BASE;
    assign m_dec         = MIDX_W'(func_reg == FUNC_FEEDBACK ? id_off : 11'(sel_reg));
    assign walk_last     = (walk_reg == LAST_M);
    assign emit_load     = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        valid_op = 1'b0;
        case (func_reg)
            FUNC_FEEDBACK:              valid_op = (id_reg >= ID_BASE) &&
                                                   (id_off < 11'(MOTOR_COUNT));
            FUNC_TICK:                  valid_op = 1'b1;
            FUNC_SET_CUR, FUNC_SET_POS: valid_op = (32'(sel_reg) < 32'(MOTOR_COUNT));
            FUNC_SEND:                  valid_op = (grp_reg != 2'd3);
            default:                    valid_op = 1'b0;
        endcase
    end

    // position before offset = raw + turns * cpt; the sign-extended offset is added where it is used
    assign pos_now = 32'(enc_reg[m_reg]) + turn_reg[m_reg] * 32'(COUNTS_PER_TURN);

    always_comb
    begin
        alu_req       = '0;
        alu_req.start = (state_reg == ST_POS);
        case (pos_step_reg)
            2'd0:
            begin
                alu_req.op = 2'd0;
                alu_req.a  = pos_now;
                alu_req.b  = {{16{off_reg[m_reg][15]}}, off_reg[m_reg]};
            end
            default:
            begin
                alu_req.op = 2'd1;
                alu_req.a  = tgt_reg;
                alu_req.b  = alu_sum[31:0];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_axis_tvalid) state_next = ST_DECODE;
            ST_DECODE:
            begin
                if (!valid_op)
                    state_next = ST_IDLE;
                else if (func_reg == FUNC_TICK)
                    state_next = ST_WALK;
                else if (func_reg == FUNC_SET_POS)
                    state_next = ST_POS;
                else
                    state_next = ST_APPLY;
            end
            ST_WALK:   if (walk_last) state_next = ST_APPLY;
            ST_POS:    if (pos_step_reg == 2'd1) state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_EMIT;
            ST_EMIT:   if (!out_valid_reg || m_axis_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign req_s     = req_reg;
    assign lim_s     = 32'(limit_reg);
    assign clamp_val = (req_s > lim_s) ? 16'(lim_s) :
                       (req_s < -lim_s) ? 16'(-lim_s) : req_reg[15:0];
    assign new_raw   = pay_reg[63:48];
    assign diff      = $signed({1'b0, new_raw}) - $signed({1'b0, enc_reg[m_reg]});

    always_comb
    begin
        grp_bytes = '0;
        for (int i = 0; i < 4; i++)
        begin
            if ((32'(grp_reg) * 4 + i < MOTOR_COUNT) && !(grp_reg == 2'd2 && i == 3))
                grp_bytes[48-16*i +: 16] = drv_reg[MIDX_W'(32'(grp_reg) * 4 + i)];
        end
    end

    always_comb
    begin
        for (int m = 0; m < MOTOR_COUNT; m++)
            mask_next[m] = link_reg[m];
        stat                   = '0;
        stat.result_kind       = KIND_STATUS;
        stat.motor_index       = 4'(m_reg);
        stat.position_counts   = pos_now + {{16{off_reg[m_reg][15]}}, off_reg[m_reg]};
        stat.speed_rpm         = spd_reg[m_reg];
        stat.measured_current  = cur_reg[m_reg];
        stat.temperature_c     = tmp_reg[m_reg];
        stat.is_connected      = link_reg[m_reg];
        stat.frames_received   = frm_reg[m_reg];
        stat.commanded_current = drv_reg[m_reg];
    end

    always_comb
    begin
        res_next = stat;
        case (func_reg)
            FUNC_TICK:
            begin
                res_next                = '0;
                res_next.result_kind    = KIND_MASK;
                res_next.connected_mask = 11'(mask_next);
            end
            FUNC_SEND:
            begin
                res_next             = '0;
                res_next.result_kind = KIND_COMMAND;
                res_next.frame_ident = (grp_reg == 2'd0) ? IDENT_GROUP0 :
                                       (grp_reg == 2'd1) ? IDENT_GROUP1 :
                                                           IDENT_GROUP2;
                res_next.frame_bytes = grp_bytes;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= CURRENT_LIMIT_RST;
            tmo_reg       <= SILENCE_TIMEOUT_RST;
            link_reg      <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            walk_reg      <= '0;
            pos_step_reg  <= '0;
            m_reg         <= '0;
            for (int m = 0; m < MOTOR_COUNT; m++)
            begin
                enc_reg[m]  <= '0;
                turn_reg[m] <= '0;
                off_reg[m]  <= '0;
                spd_reg[m]  <= '0;
                cur_reg[m]  <= '0;
                tmp_reg[m]  <= '0;
                drv_reg[m]  <= '0;
                sil_reg[m]  <= SILENCE_RST;
                frm_reg[m]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_CURRENT_LIMIT:   limit_reg <= cfg_data;
                    CFG_SILENCE_TIMEOUT: tmo_reg   <= cfg_data[7:0];
                    default:             ;
                endcase
            end
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        func_reg <= s_axis_tdata[2:0];
                        id_reg   <= s_axis_tdata[13:3];
                        pay_reg  <= s_axis_tdata[77:14];
                        sel_reg  <= s_axis_tdata[81:78];
                        req_reg  <= s_axis_tdata[113:82];
                        tgt_reg  <= s_axis_tdata[145:114];
                        grp_reg  <= s_axis_tdata[147:146];
                    end
                end
                ST_DECODE:
                begin
                    m_reg        <= m_dec;
                    walk_reg     <= '0;
                    pos_step_reg <= '0;
                end
                ST_WALK:
                begin
                    if (sil_reg[walk_reg] > 9'(tmo_reg))
                    begin
                        link_reg[walk_reg] <= 1'b0;
                        sil_reg[walk_reg]  <= 9'(tmo_reg);
                    end
                    else
                        sil_reg[walk_reg] <= sil_reg[walk_reg] + 9'd1;
                    walk_reg <= walk_reg + 1'b1;
                end
                ST_POS:
                    pos_step_reg <= pos_step_reg + 2'd1;
                ST_APPLY:
                begin
                    case (func_reg)
                        FUNC_FEEDBACK:
                        begin
                            enc_reg[m_reg] <= new_raw;
                            spd_reg[m_reg] <= pay_reg[47:32];
                            cur_reg[m_reg] <= pay_reg[31:16];
                            tmp_reg[m_reg] <= pay_reg[15:8];
                            if (diff > $signed(HALF))
                                turn_reg[m_reg] <= turn_reg[m_reg] - 32'd1;
                            else if (diff < -$signed(HALF))
                                turn_reg[m_reg] <= turn_reg[m_reg] + 32'd1;
                            sil_reg[m_reg]  <= '0;
                            frm_reg[m_reg]  <= frm_reg[m_reg] + 32'd1;
                            link_reg[m_reg] <= 1'b1;
                        end
                        FUNC_SET_CUR: drv_reg[m_reg] <= clamp_val;
                        FUNC_SET_POS: off_reg[m_reg] <= off_reg[m_reg] + alu_sum[15:0];
                        default:      ;
                    endcase
                end
                ST_EMIT:
                begin
                    if (emit_load)
                        res_reg <= res_next;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !(state_reg == ST_WALK))
        else $error("ready during tick walk");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> walk_reg <= LAST_M)
        else $error("walk index out of range");
`endif

endmodule

// ===== verif/multi_motor_feedback_tracker_tb.sv =====
`default_nettype none

module multi_motor_feedback_tracker_tb;
    import mmft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MOTORS        = MOTOR_COUNT_DEF;
    localparam int          TURN          = COUNTS_PER_TURN_DEF;
    localparam logic [2:0]  FUNC_RSVD_LO  = 3'd5;
    localparam logic [2:0]  FUNC_RSVD_HI  = 3'd7;
    localparam logic [1:0]  GROUP_NONE    = 2'd3;
    localparam int          SETTLE_CYCLES = 40;

    typedef struct {
        logic [2:0]  func;
        logic [10:0] can_id;
        logic [63:0] payload;
        logic [3:0]  motor_select;
        logic [31:0] current_request;
        logic [31:0] target_position;
        logic [1:0]  group_select;
    } item_t;

    typedef struct {
        item_t   it;
        bit      fixed;
        result_t res;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // func, can_id, payload, motor_select, current_request, target_position, group_select
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // result_kind, motor_index, position_counts, speed_rpm, measured_current, temperature_c,
    // is_connected, frames_received, frame_ident, frame_bytes, connected_mask,
    // commanded_current
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [15:0] enc_raw    [MOTORS];
    logic [31:0] turns      [MOTORS];
    logic [15:0] pos_offset [MOTORS];
    logic [15:0] speed_q    [MOTORS];
    logic [15:0] cur_q      [MOTORS];
    logic [7:0]  temp_q     [MOTORS];
    logic [15:0] drive_q    [MOTORS];
    logic [8:0]  silence_q  [MOTORS];
    logic [31:0] frames_q   [MOTORS];
    logic        link_q     [MOTORS];
    logic [14:0] limit_q;
    logic [7:0]  timeout_q;

    result_t expected_results[$];
    row_t    rows[$];
    int      errors = 0;
    int      send_idle = 0;
    int      recv_idle = 0;
    int      hold_len = 0;
    int      hold_cnt = 0;

    multi_motor_feedback_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] position_of(int m);
        return {16'd0, enc_raw[m]} + turns[m] * TURN + {{16{pos_offset[m][15]}}, pos_offset[m]};
    endfunction

    function automatic result_t status_of(int m);
        result_t r;
        r                   = '0;
        r.result_kind       = KIND_STATUS;
        r.motor_index       = m[3:0];
        r.position_counts   = position_of(m);
        r.speed_rpm         = speed_q[m];
        r.measured_current  = cur_q[m];
        r.temperature_c     = temp_q[m];
        r.is_connected      = link_q[m];
        r.frames_received   = frames_q[m];
        r.commanded_current = drive_q[m];
        return r;
    endfunction

    function automatic bit tracker_predict(item_t it, output result_t r);
        int          m;
        int          diff;
        logic [31:0] delta;
        logic signed [32:0] req;
        logic signed [32:0] lim;
        r = '0;
        case (it.func)
            FUNC_FEEDBACK:
            begin
                if (it.can_id < ID_BASE || it.can_id >= ID_BASE + MOTORS)
                    return 0;
                m = it.can_id - ID_BASE;
                diff = int'(it.payload[63:48]) - int'(enc_raw[m]);
                enc_raw[m] = it.payload[63:48];
                speed_q[m] = it.payload[47:32];
                cur_q[m]   = it.payload[31:16];
                temp_q[m]  = it.payload[15:8];
                if (diff > TURN / 2)
                    turns[m] = turns[m] - 1;
                else if (diff < -(TURN / 2))
                    turns[m] = turns[m] + 1;
                silence_q[m] = '0;
                frames_q[m]  = frames_q[m] + 1;
                link_q[m]    = 1'b1;
                r = status_of(m);
                return 1;
            end
            FUNC_TICK:
            begin
                r.result_kind = KIND_MASK;
                for (int i = 0; i < MOTORS; i++)
                begin
                    if (silence_q[i] > {1'b0, timeout_q})
                    begin
                        link_q[i]    = 1'b0;
                        silence_q[i] = {1'b0, timeout_q};
                    end
                    else
                        silence_q[i] = silence_q[i] + 1;
                    r.connected_mask[i] = link_q[i];
                end
                return 1;
            end
            FUNC_SET_CUR:
            begin
                if (it.motor_select >= MOTORS)
                    return 0;
                req = $signed({it.current_request[31], it.current_request});
                lim = $signed({18'd0, limit_q});
                if (req > lim)
                    req = lim;
                else if (req < -lim)
                    req = -lim;
                drive_q[it.motor_select] = req[15:0];
                r = status_of(it.motor_select);
                return 1;
            end
            FUNC_SET_POS:
            begin
                if (it.motor_select >= MOTORS)
                    return 0;
                delta = it.target_position - position_of(it.motor_select);
                pos_offset[it.motor_select] = pos_offset[it.motor_select] + delta[15:0];
                r = status_of(it.motor_select);
                return 1;
            end
            FUNC_SEND:
            begin
                if (it.group_select == GROUP_NONE)
                    return 0;
                r.result_kind = KIND_COMMAND;
                r.frame_ident = (it.group_select == 2'd0) ? IDENT_GROUP0 :
                                (it.group_select == 2'd1) ? IDENT_GROUP1 : IDENT_GROUP2;
                for (int i = 0; i < ((it.group_select == 2'd2) ? 3 : 4); i++)
                begin
                    m = 4 * it.group_select + i;
                    if (m < MOTORS)
                        r.frame_bytes[48 - 16 * i +: 16] = drive_q[m];
                end
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    function automatic item_t mk(logic [2:0] f, logic [10:0] id, logic [63:0] pay,
                                 logic [3:0] sel, logic [31:0] req, logic [31:0] tgt,
                                 logic [1:0] grp);
        item_t it;
        it.func            = f;
        it.can_id          = id;
        it.payload         = pay;
        it.motor_select    = sel;
        it.current_request = req;
        it.target_position = tgt;
        it.group_select    = grp;
        return it;
    endfunction

    function automatic row_t checked(item_t it);
        row_t rw;
        rw.it    = it;
        rw.fixed = 0;
        rw.res   = '0;
        return rw;
    endfunction

    function automatic row_t typed(item_t it, result_t r);
        row_t rw;
        rw.it    = it;
        rw.fixed = 1;
        rw.res   = r;
        return rw;
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int          pick;
        int          m;
        logic [31:0] step;
        it   = mk(3'($urandom), 11'($urandom), {$urandom, $urandom},
                  4'($urandom_range(MOTORS - 1)), $urandom, $urandom,
                  2'($urandom_range(2)));
        pick = $urandom_range(99);
        m    = $urandom_range(MOTORS - 1);
        if (pick < 50)
        begin
            it.func   = FUNC_FEEDBACK;
            it.can_id = 11'(ID_BASE + m);
            if ($urandom_range(3) != 0)
            begin
                step = $urandom_range(2) == 0 ? $urandom_range(TURN) - TURN / 2
                                              : $urandom_range(12000) - 6000;
                it.payload[63:48] = enc_raw[m] + step[15:0];
            end
            if ($urandom_range(9) == 0)
                it.can_id = 11'($urandom);
        end
        else if (pick < 62)
            it.func = FUNC_TICK;
        else if (pick < 76)
        begin
            it.func = FUNC_SET_CUR;
            if ($urandom_range(1) == 0)
                it.current_request = $urandom_range(70000) - 35000;
        end
        else if (pick < 86)
        begin
            it.func = FUNC_SET_POS;
            if ($urandom_range(1) == 0)
                it.target_position = $urandom_range(200000) - 100000;
        end
        else if (pick < 96)
            it.func = FUNC_SEND;
        else
        begin
            it.group_select = 2'($urandom);
            it.motor_select = 4'($urandom);
        end
        if (pick >= 62 && pick < 86 && $urandom_range(19) == 0)
            it.motor_select = 4'($urandom_range(15, MOTORS));
        return it;
    endfunction

    task automatic send_item(row_t rw);
        result_t r;
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, rw.it.group_select, rw.it.target_position,
                          rw.it.current_request, rw.it.motor_select, rw.it.payload,
                          rw.it.can_id, rw.it.func};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (tracker_predict(rw.it, r))
            expected_results.push_back(rw.fixed ? rw.res : r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [14:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_CURRENT_LIMIT)
            limit_q = val;
        else
            timeout_q = val[7:0];
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_len != 0)
        begin
            hold_cnt = hold_len;
            hold_len = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: %0h", m_axis_tdata);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("result_kind", e.result_kind, m_axis_tdata[1:0]);
                check_field("motor_index", e.motor_index, m_axis_tdata[5:2]);
                check_field("position_counts", e.position_counts, m_axis_tdata[37:6]);
                check_field("speed_rpm", e.speed_rpm, m_axis_tdata[53:38]);
                check_field("measured_current", e.measured_current, m_axis_tdata[69:54]);
                check_field("temperature_c", e.temperature_c, m_axis_tdata[77:70]);
                check_field("is_connected", e.is_connected, m_axis_tdata[78]);
                check_field("frames_received", e.frames_received, m_axis_tdata[110:79]);
                check_field("frame_ident", e.frame_ident, m_axis_tdata[121:111]);
                check_field("frame_bytes", e.frame_bytes, m_axis_tdata[185:122]);
                check_field("connected_mask", e.connected_mask, m_axis_tdata[196:186]);
                check_field("commanded_current", e.commanded_current,
                            m_axis_tdata[212:197]);
            end
        end
    end

    initial
    begin
        #4ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        result_t r;
        for (int i = 0; i < MOTORS; i++)
        begin
            enc_raw[i] = '0; turns[i] = '0; pos_offset[i] = '0; speed_q[i] = '0;
            cur_q[i] = '0; temp_q[i] = '0; drive_q[i] = '0; silence_q[i] = SILENCE_RST;
            frames_q[i] = '0; link_q[i] = 1'b0;
        end
        limit_q   = CURRENT_LIMIT_RST;
        timeout_q = SILENCE_TIMEOUT_RST;

        r = '0;
        r.result_kind = KIND_MASK;
        rows.push_back(typed(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0), r));
        r = '0;
        r.commanded_current = 16'sd16383;
        rows.push_back(typed(mk(FUNC_SET_CUR, 0, 0, 0, 32'h7FFF_FFFF, 0, 0), r));
        r.motor_index = 4'd1;
        r.commanded_current = -16'sd16383;
        rows.push_back(typed(mk(FUNC_SET_CUR, 0, 0, 1, 32'h8000_0000, 0, 0), r));
        r = '0;
        r.result_kind = KIND_COMMAND;
        r.frame_ident = IDENT_GROUP0;
        r.frame_bytes = 64'h3FFF_C001_0000_0000;
        rows.push_back(typed(mk(FUNC_SEND, 0, 0, 0, 0, 0, 0), r));
        r = '0;
        r.position_counts   = 32'd57343;
        r.speed_rpm         = 16'h8000;
        r.measured_current  = 16'h7FFF;
        r.temperature_c     = 8'hFF;
        r.is_connected      = 1'b1;
        r.frames_received   = 32'd1;
        r.commanded_current = 16'sd16383;
        rows.push_back(typed(mk(FUNC_FEEDBACK, ID_BASE, 64'hFFFF_8000_7FFF_FF00, 0, 0, 0, 0),
                             r));
        rows.push_back(checked(mk(FUNC_FEEDBACK, ID_BASE, 64'h0000_7FFF_8000_00FF, 0, 0, 0, 0)));
        rows.push_back(checked(mk(FUNC_FEEDBACK, ID_BASE + MOTORS - 1, '1, 0, 0, 0, 0)));
        rows.push_back(checked(mk(FUNC_FEEDBACK, ID_BASE + MOTORS - 1, 64'h1000_0000_0000_0000,
                                  0, 0, 0, 0)));
        rows.push_back(checked(mk(FUNC_FEEDBACK, ID_BASE - 1, '1, 0, 0, 0, 0)));
        rows.push_back(checked(mk(FUNC_FEEDBACK, ID_BASE + MOTORS, '1, 0, 0, 0, 0)));
        rows.push_back(checked(mk(FUNC_FEEDBACK, 11'h7FF, '1, 0, 0, 0, 0)));
        rows.push_back(checked(mk(FUNC_SET_POS, 0, 0, 0, 0, 32'h7FFF_FFFF, 0)));
        rows.push_back(checked(mk(FUNC_SET_POS, 0, 0, MOTORS - 1, 0, 32'h8000_0000, 0)));
        rows.push_back(checked(mk(FUNC_SET_POS, 0, 0, 4'd15, 0, 32'd5, 0)));
        rows.push_back(checked(mk(FUNC_SET_CUR, 0, 0, MOTORS, 32'd100, 0, 0)));
        rows.push_back(checked(mk(FUNC_SET_CUR, 0, 0, MOTORS - 1, 32'hFFFF_FFFF, 0, 0)));
        rows.push_back(checked(mk(FUNC_SEND, 0, 0, 0, 0, 0, 2'd1)));
        rows.push_back(checked(mk(FUNC_SEND, 0, 0, 0, 0, 0, 2'd2)));
        rows.push_back(checked(mk(FUNC_SEND, 0, 0, 0, 0, 0, GROUP_NONE)));
        rows.push_back(checked(mk(FUNC_RSVD_LO, ID_BASE, '1, 0, 0, 0, 0)));
        rows.push_back(checked(mk(FUNC_RSVD_HI, ID_BASE, '1, 0, 0, 0, 0)));
        rows.push_back(checked(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0)));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 31;
        recv_idle = 48;
        foreach (rows[i])
            send_item(rows[i]);
        drain();

        write_reg(CFG_CURRENT_LIMIT, 15'd0);
        write_reg(CFG_SILENCE_TIMEOUT, 15'd1);
        for (int i = 0; i < 330; i++)
            send_item(checked(random_item()));
        drain();

        send_idle = 48;
        recv_idle = 31;
        write_reg(CFG_CURRENT_LIMIT, 15'd30000);
        write_reg(CFG_SILENCE_TIMEOUT, 15'd255);
        for (int i = 0; i < 330; i++)
            send_item(checked(random_item()));
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_CURRENT_LIMIT, 15'd1234);
        write_reg(CFG_SILENCE_TIMEOUT, 15'd6);
        hold_len = 300;
        for (int i = 0; i < 340; i++)
        begin
            if (i == 170)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            send_item(checked(random_item()));
        end
        drain();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
